### hdl/masked_byte_pattern_search_top_macros.svh
// ----------------------------------------------------------------------------
// masked byte pattern search assertion macros
// concurrent assertion shorthands clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_TOP_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define MBPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbps assertion failed");

// next-cycle implication
`define MBPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbps assertion failed");

`endif

### hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// shared types and constants of the masked byte pattern search
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  localparam int BYTE_W         = 8;
  localparam int PATTERN_BYTES  = 32;
  localparam int PATTERN_BITS   = PATTERN_BYTES * BYTE_W;
  localparam int PAT_IDX_W      = 5;
  localparam int CARE_W         = 32;
  localparam int LENGTH_W       = 6;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 3;
  localparam int MATCH_OFFSET_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_0_7   = 3'd0,
    REG_PATTERN_8_15  = 3'd1,
    REG_PATTERN_16_23 = 3'd2,
    REG_PATTERN_24_31 = 3'd3,
    REG_CARE_BITS     = 3'd4,
    REG_PATTERN_LEN   = 3'd5
  } cfg_reg_e;

  // one byte step handed from the input stage to the scan state
  typedef struct packed {
    logic              fire;
    logic              last;
    logic [BYTE_W-1:0] data;
  } scan_step_t;

endpackage

`default_nettype wire

### hdl/mbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// configuration registers: pattern bytes, care bits and pattern length
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [mbps_pkg::PATTERN_BITS-1:0]   pattern,
  output logic [mbps_pkg::CARE_W-1:0]         care,
  output logic [mbps_pkg::LENGTH_W-1:0]       length
);
  import mbps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      care    <= '0;
      length  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_PATTERN_0_7:   pattern[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_PATTERN_8_15:  pattern[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_PATTERN_16_23: pattern[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_PATTERN_24_31: pattern[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_CARE_BITS:     care   <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LEN:   length <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/mbps_window_match.sv
// ----------------------------------------------------------------------------
// mbps_window_match
// parallel masked compare of the byte window against the pattern
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_window_match #(
  parameter int MAX_PATTERN = 32
) (
  input  logic [mbps_pkg::BYTE_W-1:0]       win [MAX_PATTERN],
  input  logic [mbps_pkg::PATTERN_BITS-1:0] pattern,
  input  logic [mbps_pkg::CARE_W-1:0]       care,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]  len,
  output logic                              hit
);
  import mbps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = ((LEN_W > PAT_IDX_W + 1) ? LEN_W : PAT_IDX_W + 1) + 1;

  logic [MAX_PATTERN-1:0] tap_ok;

  // window tap j (j steps old) lines up with pattern position len-1-j
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_tap
    logic [POS_W-1:0]     pos;
    logic                 active;
    logic                 in_range;
    logic [PAT_IDX_W-1:0] idx;

    assign pos      = POS_W'(len) - POS_W'(j + 1);
    assign active   = POS_W'(len) > POS_W'(j);
    assign in_range = pos < POS_W'(PATTERN_BYTES);
    assign idx      = pos[PAT_IDX_W-1:0];
    assign tap_ok[j] = !active || !in_range || !care[idx] ||
                       (win[j] == pattern[{idx, 3'b000} +: BYTE_W]);
  end

  assign hit = &tap_ok;

endmodule

`default_nettype wire

### hdl/mbps_scan.sv
// ----------------------------------------------------------------------------
// mbps_scan
// region scan state: byte window, byte count and first match record
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_scan #(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mbps_pkg::scan_step_t              step,
  input  logic [mbps_pkg::PATTERN_BITS-1:0] pattern,
  input  logic [mbps_pkg::CARE_W-1:0]       care,
  input  logic [mbps_pkg::LENGTH_W-1:0]     length,
  output logic                              res_found,
  output logic [OFFSET_BITS-1:0]            res_offset
);
  import mbps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = ((LEN_W > LENGTH_W) ? LEN_W : LENGTH_W) + 1;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  logic [BYTE_W-1:0]      window      [MAX_PATTERN];
  logic [BYTE_W-1:0]      window_next [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] count_next;
  logic                   match_seen;
  logic [OFFSET_BITS-1:0] first_offset;

  logic [LEN_W-1:0]       len;
  logic                   win_hit;
  logic                   hit;
  logic [OFFSET_BITS-1:0] hit_offset;
  logic                   match_now;
  logic [OFFSET_BITS-1:0] offset_now;

  // length clamp to window depth
  always_comb begin
    if (CMP_W'(length) > CMP_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(length);
    end
  end

  // shifted window, newest byte at tap 0
  always_comb begin
    window_next[0] = step.data;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign count_next = (bytes_seen == COUNT_MAX) ? bytes_seen : bytes_seen + 1'b1;

  mbps_window_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .win    (window_next),
    .pattern(pattern),
    .care   (care),
    .len    (len),
    .hit    (win_hit)
  );

  always_comb begin
    hit        = 1'b0;
    hit_offset = '0;
    if (len == '0) begin
      hit = 1'b1;
    end else if (count_next >= OFFSET_BITS'(len) && win_hit) begin
      hit        = 1'b1;
      hit_offset = (count_next == COUNT_MAX) ? COUNT_MAX
                                             : count_next - OFFSET_BITS'(len);
    end
    match_now  = match_seen || hit;
    offset_now = match_seen ? first_offset : hit_offset;
  end

  assign res_found  = match_now;
  assign res_offset = match_now ? offset_now : '0;

  always_ff @(posedge clk) begin
    if (step.fire) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      match_seen   <= 1'b0;
      first_offset <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        bytes_seen   <= '0;
        match_seen   <= 1'b0;
        first_offset <= '0;
      end else begin
        bytes_seen   <= count_next;
        match_seen   <= match_now;
        first_offset <= offset_now;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/masked_byte_pattern_search_top.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top
// scans a byte region for the first match of a masked pattern of up to 32 bytes
// ----------------------------------------------------------------------------
// usage
//   input channel: one region byte per beat (data_byte, last_byte), in_valid and
//   in_ready; last_byte marks the final byte of a region
//   output channel: one beat per region (found, match_offset), out_valid and
//   out_ready; non-final bytes produce no output beat
//   config port: cfg_we with cfg_index and cfg_data; writes take effect in the next cycle
//   path: an accepted final byte goes into the input register, then into the
//   output register once no held output beat blocks it
//   throughput: one byte per cycle save for stalls; the window compare for all pattern
//   positions is a single layer of byte comparators behind the input register
//   stall: a held output beat only blocks a final byte; other bytes keep
//   flowing through the input register while the receiver waits
//   reset: clears the config registers, the byte count, the match record and both valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_search_top #(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // byte input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mbps_pkg::BYTE_W-1:0]           data_byte,
  input  logic                                  last_byte,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  found,
  output logic [mbps_pkg::MATCH_OFFSET_W-1:0]   match_offset,
  // configuration
  input  logic                                  cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mbps_pkg::*;

  // config register outputs
  logic [PATTERN_BITS-1:0] pattern;
  logic [CARE_W-1:0]       care;
  logic [LENGTH_W-1:0]     length;

  // input register
  logic              s1_valid;
  logic              s1_last;
  logic [BYTE_W-1:0] s1_data;

  // scan interface
  scan_step_t             step;
  logic                   advance;
  logic                   res_found;
  logic [OFFSET_BITS-1:0] res_offset;
  logic [MATCH_OFFSET_W-1:0] res_offset_clamped;

  mbps_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pattern  (pattern),
    .care     (care),
    .length   (length)
  );

  // the held byte moves on unless it is a final byte and the output is stuck
  assign advance  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  assign step.fire = advance;
  assign step.last = s1_last;
  assign step.data = s1_data;

  mbps_scan #(
    .MAX_PATTERN(MAX_PATTERN),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pattern   (pattern),
    .care      (care),
    .length    (length),
    .res_found (res_found),
    .res_offset(res_offset)
  );

  // offsets beyond the output width saturate
  if (OFFSET_BITS > MATCH_OFFSET_W) begin : g_clamp
    assign res_offset_clamped =
      (res_offset > OFFSET_BITS'({MATCH_OFFSET_W{1'b1}})) ? '1
                                                          : res_offset[MATCH_OFFSET_W-1:0];
  end else begin : g_extend
    assign res_offset_clamped = MATCH_OFFSET_W'(res_offset);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      found        <= res_found;
      match_offset <= res_offset_clamped;
    end
  end

endmodule

`default_nettype wire

### hdl/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker
// port-level checks of the masked byte pattern search top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_search_top_macros.svh"

module mbps_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                last_byte,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                found,
  input  logic [mbps_pkg::MATCH_OFFSET_W-1:0] match_offset
);
  import mbps_pkg::*;

  // a stalled result beat holds
  `MBPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(found) && $stable(match_offset))

  // a miss reports offset zero
  `MBPS_ASSERT_IMP(a_miss_zero, out_valid && !found, match_offset == '0)

  // a fresh result beat comes from a final byte accepted earlier through the input register
  `MBPS_ASSERT_IMP(a_out_origin, $rose(out_valid),
                   $past(in_valid && in_ready && last_byte, 2))

endmodule

bind masked_byte_pattern_search_top mbps_checker u_mbps_checker (.*);

`default_nettype wire

### tb/sv/mbps_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbps_scan_checker
// watches the config port and both channels, predicts the per-region result
// of the masked pattern search and compares every output beat against it
// ----------------------------------------------------------------------------

module mbps_scan_checker
  import mbps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [BYTE_W-1:0]         data_byte,
  input  logic                      last_byte,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      found,
  input  logic [MATCH_OFFSET_W-1:0] match_offset,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        mismatch_count,
  output int                        pending_results,
  output int                        regions_checked,
  output int                        regions_matched
);

  localparam int SEEN_W = 32;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] offset;
  } region_result_t;

  logic [CFG_DATA_W-1:0] pattern_regs [4];
  logic [CARE_W-1:0]     care_mask;
  logic [LENGTH_W-1:0]   pattern_len;

  logic [BYTE_W-1:0]     window [PATTERN_BYTES];
  logic [SEEN_W-1:0]     seen;
  logic                  hit;
  logic [SEEN_W-1:0]     hit_offset;

  region_result_t        expected_results [$];

  initial begin
    mismatch_count  = 0;
    regions_checked = 0;
    regions_matched = 0;
  end

  assign pending_results = expected_results.size();

  function automatic logic [BYTE_W-1:0] pattern_at(int pos);
    return pattern_regs[pos / 8][(pos % 8) * BYTE_W +: BYTE_W];
  endfunction

  // oldest byte of the window lines up with pattern position 0
  function automatic bit window_hits(int len);
    for (int i = 0; i < len; i++) begin
      if (care_mask[i] && window[len - 1 - i] !== pattern_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_region();
    foreach (window[k]) window[k] = '0;
    seen       = '0;
    hit        = 1'b0;
    hit_offset = '0;
  endtask

  task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    int             len;
    region_result_t res;
    len = (pattern_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(pattern_len);
    for (int k = PATTERN_BYTES - 1; k > 0; k--) window[k] = window[k - 1];
    window[0] = b;
    if (seen != SEEN_MAX) seen++;
    if (!hit) begin
      if (len == 0) begin
        hit        = 1'b1;
        hit_offset = '0;
      end else if (seen >= len && window_hits(len)) begin
        hit        = 1'b1;
        hit_offset = (seen == SEEN_MAX) ? SEEN_MAX : seen - SEEN_W'(len);
      end
    end
    if (is_last) begin
      res.found  = hit;
      res.offset = hit ? hit_offset : '0;
      expected_results.push_back(res);
      clear_region();
    end
  endtask

  always @(posedge clk) begin : watch
    region_result_t want;
    if (rst) begin
      foreach (pattern_regs[k]) pattern_regs[k] = '0;
      care_mask   = '0;
      pattern_len = '0;
      expected_results.delete();
      clear_region();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          REG_PATTERN_0_7:   pattern_regs[0] = cfg_data;
          REG_PATTERN_8_15:  pattern_regs[1] = cfg_data;
          REG_PATTERN_16_23: pattern_regs[2] = cfg_data;
          REG_PATTERN_24_31: pattern_regs[3] = cfg_data;
          REG_CARE_BITS:     care_mask       = cfg_data[CARE_W-1:0];
          REG_PATTERN_LEN:   pattern_len     = cfg_data[LENGTH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: found=%0b offset=%0d",
                     $time, found, match_offset);
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found || match_offset !== want.offset) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: region %0d expected found=%0b offset=%0d, got found=%0b offset=%0d",
                       $time, regions_checked, want.found, want.offset, found, match_offset);
          end
          regions_checked++;
          if (want.found) regions_matched++;
        end
      end
      if (in_valid && in_ready) scan_byte(data_byte, last_byte);
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives region bytes and register settings into the masked pattern search,
// with random gaps on the input and random stalls on the result side; the
// checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------

module tb_top;
  import mbps_pkg::*;

  localparam int IDLE_PCT       = 28;
  localparam int RANDOM_ITEMS   = 450;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake
  localparam int CALM_FROM      = 150;   // random bytes sent before the calm stretch
  localparam int CALM_TO        = 270;

  logic                      clk;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic [BYTE_W-1:0]         data_byte  = '0;
  logic                      last_byte  = 1'b0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic                      found;
  logic [MATCH_OFFSET_W-1:0] match_offset;
  logic                      cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index  = REG_PATTERN_0_7;
  logic [CFG_DATA_W-1:0]     cfg_data   = '0;

  int mismatch_count, pending_results, regions_checked, regions_matched;

  // stimulus bookkeeping
  int  bytes_sent     = 0;
  int  configs_loaded = 0;
  int  idle_run       = 0;
  bit  calm           = 1'b0;  // no gaps and no stalls while set

  // current register contents, kept to plant the pattern into regions
  logic [PATTERN_BITS-1:0] cur_pattern;
  logic [CARE_W-1:0]       cur_care;
  int                      cur_len;

  masked_byte_pattern_search_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_offset (match_offset),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mbps_scan_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .match_offset    (match_offset),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .regions_checked (regions_checked),
    .regions_matched (regions_matched)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: stall at random, except during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: any beat, or a register write, restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_run <= 0;
    end else if (idle_run == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // one region byte; random gaps before it, then hold until accepted
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // drop valid, wait for every expected result, then let the pipe empty;
  // status is sampled at the falling edge to stay clear of the checker update
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller closes the burst
  task automatic set_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [PATTERN_BITS-1:0] pat,
                             input logic [CARE_W-1:0] care, input int len);
    cur_pattern = pat;
    cur_care    = care;
    cur_len     = len;
    set_reg(REG_PATTERN_0_7,   pat[63:0]);
    set_reg(REG_PATTERN_8_15,  pat[127:64]);
    set_reg(REG_PATTERN_16_23, pat[191:128]);
    set_reg(REG_PATTERN_24_31, pat[255:192]);
    set_reg(REG_CARE_BITS,     CFG_DATA_W'(care));
    set_reg(REG_PATTERN_LEN,   CFG_DATA_W'(len));
    cfg_we <= 1'b0;
    configs_loaded++;
  endtask

  // random region; plant drops the cared pattern bytes at a random start,
  // spoil then breaks one cared byte, narrow draws from a tiny alphabet so
  // accidental matches turn up
  task automatic send_region(input int rlen, input bit plant, input bit spoil,
                             input bit narrow);
    logic [BYTE_W-1:0] region [];
    int                eff_len;
    int                start;
    int                j;
    eff_len = (cur_len > PATTERN_BYTES) ? PATTERN_BYTES : cur_len;
    region  = new[rlen];
    foreach (region[i]) begin
      if (!narrow)
        region[i] = $urandom_range(255);
      else if ($urandom_range(1))
        region[i] = cur_pattern[BYTE_W * $urandom_range(PATTERN_BYTES - 1) +: BYTE_W];
      else
        region[i] = $urandom_range(3);
    end
    if (plant && eff_len > 0 && rlen >= eff_len) begin
      start = $urandom_range(rlen - eff_len);
      for (int i = 0; i < eff_len; i++)
        if (cur_care[i]) region[start + i] = cur_pattern[BYTE_W * i +: BYTE_W];
      if (spoil && (cur_care & ((64'd1 << eff_len) - 1)) != 0) begin
        j = $urandom_range(eff_len - 1);
        while (!cur_care[j]) j = (j + 1) % eff_len;
        region[start + j] ^= BYTE_W'($urandom_range(1, 255));
      end
    end
    foreach (region[i]) push_byte(region[i], i == rlen - 1);
  endtask

  task automatic directed_part();
    logic [PATTERN_BITS-1:0] pat;
    // zero length: every region matches at offset 0, even a one-byte region
    load_config('0, '0, 0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    settle();
    // partial window: the cleared window must not count as zero bytes seen
    load_config('0, '1, 3);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();
    // wildcard in the middle, first hit at offset 1, a later hit ignored
    pat        = '0;
    pat[7:0]   = 8'hA5;
    pat[23:16] = 8'hFF;
    load_config(pat, 32'h0000_0005, 3);
    push_byte(8'h12, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();
    // register change in the middle of a region applies from the next byte
    pat       = '0;
    pat[7:0]  = 8'h5A;
    pat[15:8] = 8'hC3;
    load_config(pat, 32'h0000_0003, 2);
    push_byte(8'h5A, 1'b0);
    settle();
    pat[15:8] = 8'h3C;
    load_config(pat, 32'h0000_0003, 2);
    push_byte(8'h3C, 1'b1);
    settle();
  endtask

  task automatic random_part();
    logic [PATTERN_BITS-1:0] pat;
    logic [CARE_W-1:0]       care;
    int                      len;
    int                      base;
    int                      phase;
    int                      rlen;
    int                      pick;
    bit                      plant;
    base  = bytes_sent;
    phase = 0;
    while (bytes_sent - base < RANDOM_ITEMS) begin
      settle();
      for (int k = 0; k < PATTERN_BITS / 32; k++) pat[32 * k +: 32] = $urandom();
      pick = $urandom_range(9);
      if (pick == 0) pat = '1;
      else if (pick == 1) pat = '0;
      care = $urandom();
      pick = $urandom_range(9);
      if (pick == 0) care = '1;
      else if (pick == 1) care = '0;
      else if (pick == 2) care = care & $urandom();  // sparse
      // first two phases take the longest lengths, including an over-range one
      pick = (phase == 0) ? 2 : (phase == 1) ? 1 : $urandom_range(9);
      case (pick)
        0:       len = 0;
        1:       len = PATTERN_BYTES;
        2:       len = (phase == 0) ? (1 << LENGTH_W) - 1
                                    : $urandom_range(PATTERN_BYTES + 1, (1 << LENGTH_W) - 1);
        default: len = $urandom_range(1, 6);
      endcase
      load_config(pat, care, len);
      repeat ($urandom_range(3, 8)) begin
        calm  = (bytes_sent - base >= CALM_FROM) && (bytes_sent - base < CALM_TO);
        plant = $urandom_range(99) < 60;
        if (plant)
          rlen = ((len > PATTERN_BYTES) ? PATTERN_BYTES : len) + $urandom_range(0, 12);
        else
          rlen = ($urandom_range(9) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
        if (rlen == 0) rlen = 1;
        send_region(rlen, plant, $urandom_range(99) < 25, $urandom_range(99) < 30);
      end
      calm = 1'b0;
      phase++;
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();
    random_part();
    // drain: all results back, then a wait of DRAIN_CYCLES for stray beats
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d bytes in %0d regions, %0d of them with a match, over %0d register settings",
             bytes_sent, regions_checked, regions_matched, configs_loaded);
    $display("mismatching beats: %0d, results never delivered: %0d",
             mismatch_count, pending_results);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
